### rtl/pkos_pkg.sv
package pkos_pkg;

	localparam int PAYLOAD_BITS = 49;
	localparam int RAW_BITS     = 64;
	localparam int STEP_BITS    = 8;
	localparam int STEPS        = RAW_BITS / STEP_BITS;
	localparam int SUM_W        = 40;
	localparam int CNT_W        = 32;

	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_NEW     = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_READ    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	typedef enum logic [1:0] {
		CMD_ORDER = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// one slot of the statistics store
	typedef struct packed {
		logic [31:0]      stock;
		logic [7:0]       min_sell;
		logic [7:0]       max_buy;
		logic             seen_sell;
		logic             seen_buy;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic dstep;
		logic scan;
		logic rdres;
		logic upd;
		logic emit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic dlast;
		logic match;
		logic miss;
		logic full;
	} sts_t;

endpackage

### rtl/per_key_order_stats_engine.sv
// Per-stock order statistics. Each input beat is one command: an order
// packet (bit-stuffed 64-bit word, destuffed eight raw bits a cycle), a slot
// read or a clear of all slots. Every beat yields exactly one result beat.
// An order packet is destuffed, then its key is searched (one stored slot
// compared per cycle through the slot RAM's single read port), then its slot
// gets a read-modify-write and the result is loaded; a packet dropped on a
// full table skips the update. A slot read waits for the RAM read before its
// result is loaded; a clear or an unused command loads its result directly.
// A new beat is taken once the previous result sits in the output register,
// even while that result is still stalled. Slots are handed out in order, so
// the fill count alone tells used from free slots and no clearing pass is
// needed after reset or a clear command.
module per_key_order_stats_engine #(
	parameter int NUM_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [63:0] raw_packet,
	input  logic [7:0]  slot_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] stock_id,
	output logic [7:0]  lowest_sell,
	output logic [7:0]  highest_buy,
	output logic [39:0] price_sum,
	output logic [31:0] order_count,
	output logic [7:0]  slot_used
);

	pkos_pkg::ctl_t ctl;
	pkos_pkg::sts_t sts;

	// sequence the command: destuff, search, update, emit; other commands skip to the read or the emit
	pkos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	// hold the slot store, the fill count and the result register
	pkos_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.command     (command),
		.raw_packet  (raw_packet),
		.slot_index  (slot_index),
		.status      (status),
		.stock_id    (stock_id),
		.lowest_sell (lowest_sell),
		.highest_buy (highest_buy),
		.price_sum   (price_sum),
		.order_count (order_count),
		.slot_used   (slot_used)
	);

	// a taken beat always leaves the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// a dropped packet reports nothing but its stock id
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pkos_pkg::ST_FULL |->
		lowest_sell == 8'd0 && highest_buy == 8'd0 && price_sum == 40'd0 &&
		order_count == 32'd0)
		else $error("dropped packet carries statistics");

	// a new slot with a nonzero stock id has counted at least this order
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == pkos_pkg::ST_UPDATED || status == pkos_pkg::ST_NEW) &&
		stock_id != 32'd0 |-> order_count != 32'd0 || status == pkos_pkg::ST_UPDATED)
		else $error("new slot with zero count");

	// an empty read reports no stock
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pkos_pkg::ST_EMPTY |-> stock_id == 32'd0 &&
		order_count == 32'd0)
		else $error("empty slot read carries data");

endmodule

### rtl/pkos_ram.sv
module pkos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/pkos_dp.sv
module pkos_dp #(
	parameter int NUM_SLOTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pkos_pkg::ctl_t     ctl,
	output pkos_pkg::sts_t     sts,
	input  logic [1:0]         command,
	input  logic [63:0]        raw_packet,
	input  logic [7:0]         slot_index,
	output logic [2:0]         status,
	output logic [31:0]        stock_id,
	output logic [7:0]         lowest_sell,
	output logic [7:0]         highest_buy,
	output logic [39:0]        price_sum,
	output logic [31:0]        order_count,
	output logic [7:0]         slot_used
);

	localparam int AW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int SUM_W_P1 = pkos_pkg::SUM_W + 1;

	typedef struct packed {
		logic [pkos_pkg::PAYLOAD_BITS-1:0] res;
		logic [5:0]                        pos;
		logic [2:0]                        ones;
		logic                              skip;
	} dsr_t;

	// destuff one byte of raw bits, bit 0 first
	function automatic dsr_t dstep8(dsr_t s, logic [pkos_pkg::STEP_BITS-1:0] b);
		dsr_t r;
		r = s;
		for (int j = 0; j < pkos_pkg::STEP_BITS; j++) begin
			if (r.skip) begin
				r.skip = 1'b0;
			end else if (r.pos < 6'(pkos_pkg::PAYLOAD_BITS)) begin
				if (b[j]) begin
					r.res[r.pos] = 1'b1;
					r.pos = r.pos + 6'd1;
					if (r.ones == 3'd4) begin
						r.ones = 3'd0;
						r.skip = 1'b1;
					end else begin
						r.ones = r.ones + 3'd1;
					end
				end else begin
					r.ones = 3'd0;
					r.pos = r.pos + 6'd1;
				end
			end
		end
		return r;
	endfunction

	logic [63:0]          raw_q;
	logic [2:0]           dcnt_q;
	dsr_t                 ds_q;
	logic [CW-1:0]        taken_q;
	logic [CW-1:0]        k_q;
	logic                 rv_s1;
	logic [AW-1:0]        ra_s1;
	logic                 hit_q;
	logic [7:0]           idx_q;
	pkos_pkg::rec_t       rec_q;
	logic [2:0]           pst_q;
	logic [AW-1:0]        slot_q;
	logic [7:0]           used_q;

	pkos_pkg::rec_t       rdata_rec;
	logic [pkos_pkg::REC_W-1:0] rdata;
	pkos_pkg::rec_t       new_rec;
	pkos_pkg::rec_t       fresh;
	logic [31:0]          id;
	logic                 sell;
	logic [7:0]           price;
	logic                 match;
	logic                 issue;
	logic                 miss;
	logic                 full;
	logic                 rd_cmd;
	logic [CW+7:0]        idx_w;
	logic [AW+7:0]        idx_a;
	logic [CW+7:0]        taken_w;
	logic [AW+7:0]        ra_w;
	logic                 re;
	logic [AW-1:0]        raddr;
	logic [SUM_W_P1-1:0]  sum_w;

	assign id    = ds_q.res[31:0];
	assign sell  = ds_q.res[32];
	assign price = ds_q.res[48:41];

	assign rdata_rec = pkos_pkg::rec_t'(rdata);
	assign full      = taken_q == CW'(NUM_SLOTS);
	assign match     = ctl.scan && rv_s1 && (rdata_rec.stock == id);
	assign issue     = ctl.scan && !match && (k_q < taken_q);
	assign miss      = ctl.scan && !match && !rv_s1 && !(k_q < taken_q);

	assign rd_cmd  = ctl.accept && (pkos_pkg::cmd_t'(command) == pkos_pkg::CMD_READ);
	assign idx_w   = (CW + 8)'(slot_index);
	assign idx_a   = (AW + 8)'(slot_index);
	assign taken_w = (CW + 8)'(taken_q);
	assign ra_w    = (AW + 8)'(ra_s1);
	assign re      = rd_cmd || issue;
	assign raddr   = rd_cmd ? idx_a[AW-1:0] : k_q[AW-1:0];

	assign sts.dlast = dcnt_q == 3'(pkos_pkg::STEPS - 1);
	assign sts.match = match;
	assign sts.miss  = miss;
	assign sts.full  = full;

	always_comb begin
		fresh           = '0;
		fresh.stock     = id;
		fresh.min_sell  = 8'hFF;
	end

	// fold one order into the slot record
	always_comb begin
		new_rec = rec_q;
		sum_w   = SUM_W_P1'(rec_q.sum) + SUM_W_P1'(price);
		if (sell) begin
			new_rec.seen_sell = 1'b1;
			if (price < rec_q.min_sell) begin
				new_rec.min_sell = price;
			end
		end else begin
			new_rec.seen_buy = 1'b1;
			if (price > rec_q.max_buy) begin
				new_rec.max_buy = price;
			end
		end
		new_rec.sum = sum_w[pkos_pkg::SUM_W] ? '1 : sum_w[pkos_pkg::SUM_W-1:0];
		if (rec_q.count != '1) begin
			new_rec.count = rec_q.count + 32'd1;
		end
	end

	pkos_ram #(
		.WIDTH (pkos_pkg::REC_W),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.upd),
		.waddr (slot_q),
		.wdata (new_rec),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			rv_s1   <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (ctl.accept && pkos_pkg::cmd_t'(command) == pkos_pkg::CMD_CLEAR) begin
				taken_q <= '0;
			end else if (miss && !full) begin
				taken_q <= taken_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			raw_q  <= raw_packet;
			dcnt_q <= '0;
			ds_q   <= '0;
			k_q    <= '0;
			idx_q  <= slot_index;
			hit_q  <= idx_w < taken_w;
			rec_q  <= '0;
			pst_q  <= pkos_pkg::ST_UPDATED;
			used_q <= rd_cmd ? slot_index : 8'd0;
		end
		if (ctl.dstep) begin
			ds_q   <= dstep8(ds_q, raw_q[dcnt_q*pkos_pkg::STEP_BITS +: pkos_pkg::STEP_BITS]);
			dcnt_q <= dcnt_q + 3'd1;
		end
		if (issue) begin
			ra_s1 <= k_q[AW-1:0];
			k_q   <= k_q + CW'(1);
		end
		if (match) begin
			rec_q  <= rdata_rec;
			slot_q <= ra_s1;
			used_q <= ra_w[7:0];
			pst_q  <= pkos_pkg::ST_UPDATED;
		end else if (miss && full) begin
			rec_q.stock <= id;
			pst_q       <= pkos_pkg::ST_FULL;
		end else if (miss) begin
			rec_q  <= fresh;
			slot_q <= taken_q[AW-1:0];
			used_q <= taken_w[7:0];
			pst_q  <= pkos_pkg::ST_NEW;
		end
		if (ctl.rdres) begin
			if (hit_q) begin
				rec_q <= rdata_rec;
				pst_q <= pkos_pkg::ST_READ;
			end else begin
				pst_q <= pkos_pkg::ST_EMPTY;
			end
			used_q <= idx_q;
		end
		if (ctl.upd) begin
			rec_q <= new_rec;
		end
		if (ctl.emit) begin
			status      <= pst_q;
			stock_id    <= rec_q.stock;
			lowest_sell <= rec_q.seen_sell ? rec_q.min_sell : 8'd0;
			highest_buy <= rec_q.seen_buy ? rec_q.max_buy : 8'd0;
			price_sum   <= rec_q.sum;
			order_count <= rec_q.count;
			slot_used   <= used_q;
		end
	end

endmodule

### rtl/pkos_ctrl.sv
module pkos_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     command,
	output logic           out_valid,
	input  logic           out_stall,
	output pkos_pkg::ctl_t ctl,
	input  pkos_pkg::sts_t sts
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DESTUFF = 6'b000010,
		S_SCAN    = 6'b000100,
		S_UPD     = 6'b001000,
		S_RDWAIT  = 6'b010000,
		S_EMIT    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl        = '0;
		ctl.accept = (state_q == S_IDLE) && in_valid;
		ctl.dstep  = state_q == S_DESTUFF;
		ctl.scan   = state_q == S_SCAN;
		ctl.rdres  = state_q == S_RDWAIT;
		ctl.upd    = state_q == S_UPD;
		ctl.emit   = (state_q == S_EMIT) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (pkos_pkg::cmd_t'(command))
						pkos_pkg::CMD_ORDER: state_d = S_DESTUFF;
						pkos_pkg::CMD_READ:  state_d = S_RDWAIT;
						default:             state_d = S_EMIT;
					endcase
				end
			end
			S_DESTUFF: if (sts.dlast) state_d = S_SCAN;
			S_SCAN: begin
				if (sts.match) begin
					state_d = S_UPD;
				end else if (sts.miss) begin
					state_d = sts.full ? S_EMIT : S_UPD;
				end
			end
			S_UPD:    state_d = S_EMIT;
			S_RDWAIT: state_d = S_EMIT;
			S_EMIT:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
